@@ sv/mfs_pkg.sv @@
// ---------------------------------------------------------------------------
// mfs_pkg: shared types, constants and tables
// Word formats, network layout and the sigmoid / exp lookup tables.
// ---------------------------------------------------------------------------
package mfs_pkg;

  localparam int unsigned ValueW    = 16;
  localparam int unsigned FracBits  = 12;
  localparam int unsigned InCount   = 2;
  localparam int unsigned HidFirst  = 3;
  localparam int unsigned HidSecond = 2;
  localparam int unsigned OutCount  = 2;
  localparam int unsigned StoreDep  = 32;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned ActN      = 3;   // widest layer
  localparam int unsigned IdxW      = 2;
  localparam int unsigned AccW      = 40;
  localparam int unsigned ExpW      = 17;
  localparam int unsigned SumW      = 20;
  localparam int unsigned NumW      = 34;
  localparam int unsigned QuoW      = 17;

  localparam int unsigned OffW1 = 0;
  localparam int unsigned OffB1 = OffW1 + InCount * HidFirst;
  localparam int unsigned OffW2 = OffB1 + HidFirst;
  localparam int unsigned OffB2 = OffW2 + HidFirst * HidSecond;
  localparam int unsigned OffW3 = OffB2 + HidSecond;
  localparam int unsigned OffB3 = OffW3 + HidSecond * OutCount;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_INFER = 1'b1;

  localparam logic [1:0] LAYER_1 = 2'd0;
  localparam logic [1:0] LAYER_2 = 2'd1;
  localparam logic [1:0] LAYER_3 = 2'd2;

  typedef struct packed {
    logic                     func;
    logic [4:0]               param_index;
    logic signed [ValueW-1:0] param_value;
    logic signed [ValueW-1:0] sample_first;
    logic signed [ValueW-1:0] sample_second;
  } in_word_t;

  typedef struct packed {
    logic [15:0] prob_first;
    logic [15:0] prob_second;
  } out_word_t;

  typedef struct packed {
    logic     valid;
    in_word_t word;
  } queue_head_t;

  typedef struct packed {
    logic [IdxW-1:0]  n_in;
    logic [IdxW-1:0]  n_out;
    logic [AddrW-1:0] w_off;
    logic [AddrW-1:0] b_off;
  } layer_cfg_t;

  function automatic layer_cfg_t layer_cfg(input logic [1:0] layer);
    layer_cfg_t c;
    case (layer)
      LAYER_1: c = '{IdxW'(InCount), IdxW'(HidFirst), AddrW'(OffW1), AddrW'(OffB1)};
      LAYER_2: c = '{IdxW'(HidFirst), IdxW'(HidSecond), AddrW'(OffW2), AddrW'(OffB2)};
      default: c = '{IdxW'(HidSecond), IdxW'(OutCount), AddrW'(OffW3), AddrW'(OffB3)};
    endcase
    return c;
  endfunction

  function automatic logic signed [ValueW-1:0] init_word(input logic [AddrW-1:0] i);
    logic signed [ValueW-1:0] v;
    case (i)
      5'd0, 5'd6, 5'd9, 5'd15, 5'd17, 5'd21: v = 16'sd410;
      5'd3, 5'd7, 5'd11, 5'd19, 5'd16, 5'd22: v = 16'sd819;
      5'd1, 5'd8, 5'd13, 5'd18:               v = 16'sd1229;
      5'd4, 5'd10, 5'd20:                     v = 16'sd1638;
      5'd2, 5'd12:                            v = 16'sd2048;
      5'd5, 5'd14:                            v = 16'sd2458;
      default:                                v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [11:0] sig_tab(input logic [4:0] i);
    logic [11:0] v;
    case (i)
      5'd0:  v = 12'd1;    5'd1:  v = 12'd4;    5'd2:  v = 12'd10;
      5'd3:  v = 12'd27;   5'd4:  v = 12'd74;   5'd5:  v = 12'd194;
      5'd6:  v = 12'd488;  5'd7:  v = 12'd1102; 5'd8:  v = 12'd2048;
      5'd9:  v = 12'd2994; 5'd10: v = 12'd3608; 5'd11: v = 12'd3902;
      5'd12: v = 12'd4022; 5'd13: v = 12'd4069; 5'd14: v = 12'd4086;
      5'd15: v = 12'd4092; default: v = 12'd4095;
    endcase
    return v;
  endfunction

  function automatic logic [ExpW-1:0] exp_int(input logic [3:0] n);
    logic [ExpW-1:0] v;
    case (n)
      4'd0:  v = 17'd65536; 4'd1:  v = 17'd24109; 4'd2: v = 17'd8869;
      4'd3:  v = 17'd3263;  4'd4:  v = 17'd1200;  4'd5: v = 17'd442;
      4'd6:  v = 17'd162;   4'd7:  v = 17'd60;    4'd8: v = 17'd22;
      4'd9:  v = 17'd8;     4'd10: v = 17'd3;     4'd11: v = 17'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [ExpW-1:0] exp_qtr(input logic [2:0] q);
    logic [ExpW-1:0] v;
    case (q)
      3'd0:    v = 17'd65536;
      3'd1:    v = 17'd51039;
      3'd2:    v = 17'd39750;
      3'd3:    v = 17'd30957;
      default: v = 17'd24109;
    endcase
    return v;
  endfunction

endpackage

@@ sv/mfs_front.sv @@
// ---------------------------------------------------------------------------
// mfs_front: input word queue
// Takes words from the input channel into a two-entry queue for the engine.
// ---------------------------------------------------------------------------
module mfs_front import mfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_word_i,
  output queue_head_t head_o,
  input  logic        pop_i
);

  in_word_t    mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        push, pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = pop_i && (count_q != 2'd0);
  assign head_o.valid = (count_q != 2'd0);
  assign head_o.word  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2 && !pop) |=> (count_q == 2'd2)) else $error("full queue lost a word");

  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0) |=> (count_q != 2'd2)) else $error("queue filled from empty in one cycle");

endmodule

@@ sv/mfs_engine.sv @@
// ---------------------------------------------------------------------------
// mfs_engine: parameter store and shared arithmetic sequencer
// Executes loads and inferences one at a time on a single MAC datapath.
// ---------------------------------------------------------------------------
module mfs_engine import mfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_head_t head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_word_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_BIAS, S_MAC, S_ROUND, S_SIG, S_NEXT, S_MAX,
    S_EXP1, S_EXP2, S_DIVI, S_DIV, S_DONE
  } state_e;

  state_e                   state_q;
  logic signed [ValueW-1:0] store_q [StoreDep];
  logic signed [ValueW-1:0] act_q [ActN];
  logic signed [ValueW-1:0] res_q [ActN];
  logic [1:0]               layer_q;
  logic [IdxW-1:0]          j_q, k_q;
  logic signed [AccW-1:0]   acc_q;
  logic signed [ValueW-1:0] mx_q;
  logic [3:0]               n_q;
  logic [ExpW-1:0]          frac_q;
  logic [ExpW-1:0]          e_q [2];
  logic [SumW-1:0]          sum_q;
  logic [NumW-1:0]          num_q;
  logic [SumW-1:0]          rem_q;
  logic [QuoW-1:0]          quo_q;
  logic [4:0]               bit_q;
  logic [15:0]              p_q [2];
  logic                     out_valid_q;
  out_word_t                out_word_q;

  layer_cfg_t               cfg;
  logic [7:0]               w_addr;
  logic signed [ValueW-1:0] w_val, b_val;
  logic signed [2*ValueW-1:0] prod;
  logic signed [AccW-1:0]   rnd;
  logic signed [ValueW-1:0] rnd_sat;
  logic [15:0]              sig_u;
  logic [11:0]              sig_lo, sig_hi, sig_d;
  logic [23:0]              sig_ip;
  logic [11:0]              sig_val;
  logic signed [ValueW:0]   ex_diff;
  logic [15:0]              ex_u;
  logic [ExpW-1:0]          ex_a, ex_b, ex_dd, ex_frac;
  logic [26:0]              ex_m;
  logic [33:0]              ex_p;
  logic [ExpW-1:0]          ex_e;
  logic [NumW-1:0]          div_num;
  logic [SumW:0]            div_t;
  logic                     div_ge;
  logic [QuoW-1:0]          quo_nxt;
  logic [15:0]              p_sat;

  assign cfg    = layer_cfg(layer_q);
  assign w_addr = 8'(cfg.w_off) + 8'(k_q) * 8'(cfg.n_out) + 8'(j_q);
  assign w_val  = store_q[w_addr[AddrW-1:0]];
  assign b_val  = store_q[cfg.b_off + AddrW'(j_q)];
  assign prod   = act_q[k_q] * w_val;

  // round half up to Q4.12, then saturate
  assign rnd = (acc_q + AccW'(2048)) >>> FracBits;
  always_comb begin
    if (rnd > AccW'(32767))        rnd_sat = 16'sh7fff;
    else if (rnd < -AccW'(32768))  rnd_sat = 16'sh8000;
    else                           rnd_sat = rnd[ValueW-1:0];
  end

  // sigmoid: interpolate between integer points
  assign sig_u   = {~res_q[j_q][15], res_q[j_q][14:0]};
  assign sig_lo  = sig_tab({1'b0, sig_u[15:12]});
  assign sig_hi  = sig_tab({1'b0, sig_u[15:12]} + 5'd1);
  assign sig_d   = sig_hi - sig_lo;
  assign sig_ip  = 24'(sig_d * sig_u[11:0]) + 24'd2048;
  assign sig_val = sig_lo + sig_ip[23:12];

  // exp(-u): integer part times quarter-step interpolation
  assign ex_diff = {mx_q[15], mx_q} - {res_q[j_q][15], res_q[j_q]};
  assign ex_u    = ex_diff[15:0];
  assign ex_a    = exp_qtr({1'b0, ex_u[11:10]});
  assign ex_b    = exp_qtr({1'b0, ex_u[11:10]} + 3'd1);
  assign ex_dd   = ex_a - ex_b;
  assign ex_m    = 27'(ex_dd * ex_u[9:0]) + 27'd512;
  assign ex_frac = ex_a - ExpW'(ex_m >> 10);
  assign ex_p    = 34'(exp_int(n_q) * frac_q) + 34'd32768;
  assign ex_e    = ex_p[32:16];

  // restoring divide, one quotient bit per cycle
  assign div_num = {e_q[j_q[0]], 16'b0} + NumW'(sum_q >> 1);
  assign div_t   = {rem_q, num_q[bit_q]};
  assign div_ge  = (div_t >= {1'b0, sum_q});
  always_comb begin
    quo_nxt = quo_q;
    quo_nxt[bit_q] = div_ge;
  end
  assign p_sat = quo_nxt[16] ? 16'hffff : quo_nxt[15:0];

  assign pop_o       = (state_q == S_IDLE) && head_i.valid;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      layer_q     <= LAYER_1;
      j_q         <= '0;
      k_q         <= '0;
      for (int i = 0; i < StoreDep; i++) begin
        store_q[i] <= init_word(AddrW'(i));
      end
    end else begin
      // S_DONE owns the valid flag while it hands over a word
      if (out_ready_i && state_q != S_DONE) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (head_i.valid) begin
            if (head_i.word.func == FUNC_LOAD) begin
              store_q[head_i.word.param_index] <= head_i.word.param_value;
            end else begin
              act_q[0] <= head_i.word.sample_first;
              act_q[1] <= head_i.word.sample_second;
              act_q[2] <= '0;
              layer_q  <= LAYER_1;
              j_q      <= '0;
              state_q  <= S_BIAS;
            end
          end
        end
        S_BIAS: begin
          acc_q   <= AccW'(b_val) <<< FracBits;
          k_q     <= '0;
          state_q <= S_MAC;
        end
        S_MAC: begin
          acc_q <= acc_q + AccW'(prod);
          if (k_q == cfg.n_in - IdxW'(1)) state_q <= S_ROUND;
          else k_q <= k_q + IdxW'(1);
        end
        S_ROUND: begin
          res_q[j_q] <= rnd_sat;
          state_q    <= (layer_q == LAYER_3) ? S_NEXT : S_SIG;
        end
        S_SIG: begin
          res_q[j_q] <= {4'b0, sig_val};
          state_q    <= S_NEXT;
        end
        S_NEXT: begin
          if (j_q == cfg.n_out - IdxW'(1)) begin
            if (layer_q == LAYER_3) begin
              mx_q    <= res_q[0];
              j_q     <= IdxW'(1);
              state_q <= S_MAX;
            end else begin
              for (int i = 0; i < ActN; i++) act_q[i] <= res_q[i];
              layer_q <= layer_q + 2'd1;
              j_q     <= '0;
              state_q <= S_BIAS;
            end
          end else begin
            j_q     <= j_q + IdxW'(1);
            state_q <= S_BIAS;
          end
        end
        S_MAX: begin
          if (res_q[j_q] > mx_q) mx_q <= res_q[j_q];
          if (j_q == IdxW'(OutCount - 1)) begin
            j_q     <= '0;
            sum_q   <= '0;
            state_q <= S_EXP1;
          end else begin
            j_q <= j_q + IdxW'(1);
          end
        end
        S_EXP1: begin
          n_q     <= ex_u[15:12];
          frac_q  <= ex_frac;
          state_q <= S_EXP2;
        end
        S_EXP2: begin
          e_q[j_q[0]] <= ex_e;
          sum_q       <= sum_q + SumW'(ex_e);
          if (j_q == IdxW'(OutCount - 1)) begin
            j_q     <= '0;
            state_q <= S_DIVI;
          end else begin
            j_q     <= j_q + IdxW'(1);
            state_q <= S_EXP1;
          end
        end
        S_DIVI: begin
          num_q   <= div_num;
          rem_q   <= SumW'(div_num >> QuoW);
          quo_q   <= '0;
          bit_q   <= 5'(QuoW - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= div_ge ? SumW'(div_t - {1'b0, sum_q}) : div_t[SumW-1:0];
          quo_q <= quo_nxt;
          if (bit_q == 5'd0) begin
            p_q[j_q[0]] <= p_sat;
            if (j_q == IdxW'(1)) begin
              state_q <= S_DONE;
            end else begin
              j_q     <= j_q + IdxW'(1);
              state_q <= S_DIVI;
            end
          end else begin
            bit_q <= bit_q - 5'd1;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_word_q  <= '{prob_first: p_q[0], prob_second: p_q[1]};
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (sum_q != '0)) else $error("softmax divide by zero");

  a_sig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SIG) |-> (sig_val <= 12'd4095 && sig_val >= sig_lo))
    else $error("sigmoid out of range");

  a_exp_arg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXP1) |-> !ex_diff[ValueW]) else $error("logit above maximum");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE)) else $error("result without inference");

endmodule

@@ sv/mlp_forward_sigmoid_softmax_core.sv @@
// ---------------------------------------------------------------------------
// mlp_forward_sigmoid_softmax_core: 2-3-2-2 MLP inference, Q4.12 fixed point
// Sigmoid hidden layers, max-subtracted softmax output, writable weights.
// ---------------------------------------------------------------------------
// Each input word is either a load (func = 0), which writes one Q4.12 entry
// of the 32-word parameter store and gives no result, or an inference
// (func = 1), which gives one result word with two Q0.16 class probabilities.
// Words enter a two-deep queue and are executed strictly in order, so a load
// takes effect for every later inference. An inference runs on the single
// shared multiply-add datapath: 16 multiply-accumulates with their rounding
// and five sigmoids, two exp evaluations, and a 17-bit restoring divide per
// class.
// The store resets to the network's trained weights and biases.
module mlp_forward_sigmoid_softmax_core import mfs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  // queue head and pop between the front and the engine
  queue_head_t head;
  logic        pop;

  mfs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // engine holds the store, the sequencer and the result register
  mfs_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
